// ===== rtl/address_region_decoder_top_macros.svh =====
// assertion macros shared by the address region decoder
`ifndef ADDRESS_REGION_DECODER_TOP_MACROS_SVH
`define ADDRESS_REGION_DECODER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ARD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ARD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ard_pkg.sv =====
// shared types, codes and constants of the address region decoder
package ard_pkg;

  localparam int unsigned MAX_REGIONS_DEF = 16;
  localparam int unsigned WRITE_BIT_DEF   = 31;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned SIZE_W   = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned RIDX_W   = 4;

  // item kinds
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REG    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ACCESS = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_OFFSET,
    S_CHECK,
    S_RESULT
  } state_t;

  // write request into the region table
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
  } tbl_wr_t;

endpackage

// ===== rtl/ard_req_if.sv =====
// request and response channel interfaces of the address region decoder
interface ard_req_if;
  import ard_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ADDR_W-1:0] address;
  logic [SIZE_W-1:0] region_size;

  modport source (output valid, mode, address, region_size, input ready);
  modport sink (input valid, mode, address, region_size, output ready);
endinterface

interface ard_rsp_if;
  import ard_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [RIDX_W-1:0]   region_index;
  logic [SIZE_W-1:0]   offset;
  logic                is_write;

  modport source (output valid, status, region_index, offset, is_write, input ready);
  modport sink (input valid, status, region_index, offset, is_write, output ready);
endinterface

// ===== rtl/ard_table.sv =====
// region table: base and size memories, one write and one registered read port
module ard_table #(
  parameter int unsigned DEPTH = ard_pkg::MAX_REGIONS_DEF,
  parameter int unsigned IDX_W = 4
) (
  input  logic                        clk,
  input  ard_pkg::tbl_wr_t            wr,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic                        rd_en,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [ard_pkg::ADDR_W-1:0]  rd_base,
  output logic [ard_pkg::SIZE_W-1:0]  rd_size
);
  import ard_pkg::*;

  logic [ADDR_W-1:0] bases [DEPTH];
  logic [SIZE_W-1:0] sizes [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      bases[wr_addr] <= wr.base;
      sizes[wr_addr] <= wr.size;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_base <= bases[rd_addr];
      rd_size <= sizes[rd_addr];
    end
  end

endmodule

// ===== rtl/ard_alu.sv =====
// shared subtract unit: two 32-bit subtractions with borrow out
module ard_alu (
  input  logic [ard_pkg::ADDR_W-1:0] opa,
  input  logic [ard_pkg::ADDR_W-1:0] opb,
  input  logic [ard_pkg::ADDR_W-1:0] opc,
  output logic [ard_pkg::ADDR_W:0]   diff_ab,
  output logic [ard_pkg::ADDR_W:0]   diff_bc
);
  import ard_pkg::*;

  // msb of each difference is the borrow
  assign diff_ab = {1'b0, opa} - {1'b0, opb};
  assign diff_bc = {1'b0, opb} - {1'b0, opc};

endmodule

// ===== rtl/address_region_decoder_top.sv =====
// address region decoder: table of address regions with region lookup for accesses
//
// Request channel req carries mode, address and region_size; one beat per item.
// Response channel rsp returns exactly one beat per request: status,
// region_index, offset and is_write.
// Clear and register items go from the request beat to S_RESULT and then to the
// output register. An access item walks the table one entry per cycle through a
// single memory read port and a shared subtract unit, then passes S_OFFSET,
// S_CHECK and S_RESULT to the output register; the walk sets the time.
// req.ready is high only while no item is in work; one item is handled at a
// time, so the next request beat comes no earlier than the response is loaded
// into the output register. The response sits in an output register, so the next
// request beat may be taken while a finished response still waits for rsp.ready.
// If the receiver stalls for longer, the finished item waits in the sequencer and
// req.ready stays low until the output register frees up.
// Reset (rst, synchronous) empties the table and drops rsp.valid; table
// contents themselves are not cleared, so no clearing pass is needed.
`include "address_region_decoder_top_macros.svh"

module address_region_decoder_top #(
  parameter int unsigned MAX_REGIONS = ard_pkg::MAX_REGIONS_DEF,
  parameter int unsigned WRITE_BIT   = ard_pkg::WRITE_BIT_DEF
) (
  input logic      clk,
  input logic      rst,
  ard_req_if.sink   req,
  ard_rsp_if.source rsp
);
  import ard_pkg::*;

  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned XW = (IW > RIDX_W) ? IW : RIDX_W;
  localparam logic [CW-1:0]     FULL_COUNT = CW'(MAX_REGIONS);
  localparam logic [ADDR_W-1:0] WMASK      = ADDR_W'(1) << WRITE_BIT;

  state_t state, state_next;

  logic [CW-1:0]       count;
  logic [CW-1:0]       scan_ptr;
  logic                pend;
  logic [IW-1:0]       pend_idx;
  logic [ADDR_W-1:0]   acc_addr;
  logic                acc_wr;
  logic                found;
  logic [ADDR_W-1:0]   best_base;
  logic [SIZE_W-1:0]   best_size;
  logic [IW-1:0]       best_idx;
  logic [ADDR_W-1:0]   off_q;

  logic [STATUS_W-1:0] res_status;
  logic [RIDX_W-1:0]   res_idx;
  logic [SIZE_W-1:0]   res_off;
  logic                res_wr;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [RIDX_W-1:0]   out_idx;
  logic [SIZE_W-1:0]   out_off;
  logic                out_wr;

  logic                in_ready;
  logic                accept;
  logic                out_free;
  logic                rd_en;
  logic [ADDR_W-1:0]   alu_a, alu_b, alu_c;
  logic [ADDR_W:0]     diff_ab, diff_bc;
  logic [ADDR_W-1:0]   rd_base;
  logic [SIZE_W-1:0]   rd_size;
  tbl_wr_t             tbl_wr;
  logic [XW-1:0]       slot_ext, best_ext;

  assign accept   = req.valid && in_ready;
  assign out_free = !out_valid || rsp.ready;
  assign slot_ext = XW'(count[IW-1:0]);
  assign best_ext = XW'(best_idx);

  // table write on an accepted register beat with room left
  always_comb begin
    tbl_wr.en   = accept && (req.mode == MODE_REG) && (count != FULL_COUNT);
    tbl_wr.base = req.address;
    tbl_wr.size = req.region_size;
  end

  ard_table #(
    .DEPTH (MAX_REGIONS),
    .IDX_W (IW)
  ) u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .wr_addr (count[IW-1:0]),
    .rd_en   (rd_en),
    .rd_addr (scan_ptr[IW-1:0]),
    .rd_base (rd_base),
    .rd_size (rd_size)
  );

  ard_alu u_alu (
    .opa     (alu_a),
    .opb     (alu_b),
    .opc     (alu_c),
    .diff_ab (diff_ab),
    .diff_bc (diff_bc)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = (req.mode == MODE_ACCESS) ? S_SCAN : S_RESULT;
        end
      end
      S_SCAN: begin
        if (!rd_en && !pend) begin
          state_next = S_OFFSET;
        end
      end
      S_OFFSET: state_next = S_CHECK;
      S_CHECK:  state_next = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: ready, table read and subtract unit operands
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    alu_a    = '0;
    alu_b    = '0;
    alu_c    = '0;
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_SCAN: begin
        rd_en = (scan_ptr != count);
        alu_a = acc_addr;
        alu_b = rd_base;
        alu_c = best_base;
      end
      S_OFFSET: begin
        alu_a = acc_addr;
        alu_b = best_base;
      end
      S_CHECK: begin
        alu_a = off_q;
        alu_b = ADDR_W'(best_size);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign req.ready = in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // region count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && (req.mode == MODE_CLEAR)) begin
      count <= '0;
    end else if (tbl_wr.en) begin
      count <= count + CW'(1);
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_ptr <= '0;
      pend     <= 1'b0;
      found    <= 1'b0;
    end else if (accept) begin
      scan_ptr <= '0;
      pend     <= 1'b0;
      found    <= 1'b0;
    end else if (state == S_SCAN) begin
      pend <= rd_en;
      if (rd_en) begin
        scan_ptr <= scan_ptr + CW'(1);
      end
      // candidate: base not above address and not below best so far
      if (pend && !diff_ab[ADDR_W] && (!found || !diff_bc[ADDR_W])) begin
        found <= 1'b1;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      acc_addr <= req.address & ~WMASK;
      acc_wr   <= req.address[WRITE_BIT];
    end
    if (state == S_SCAN) begin
      if (rd_en) begin
        pend_idx <= scan_ptr[IW-1:0];
      end
      if (pend && !diff_ab[ADDR_W] && (!found || !diff_bc[ADDR_W])) begin
        best_base <= rd_base;
        best_size <= rd_size;
        best_idx  <= pend_idx;
      end
    end
    if (state == S_OFFSET) begin
      off_q <= diff_ab[ADDR_W-1:0];
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= ST_OK;
      res_idx    <= '0;
      res_off    <= '0;
      res_wr     <= 1'b0;
      if ((req.mode == MODE_REG) && (count == FULL_COUNT)) begin
        res_status <= ST_FULL;
      end else if (req.mode == MODE_REG) begin
        res_idx <= slot_ext[RIDX_W-1:0];
      end
    end else if (state == S_CHECK) begin
      res_wr <= acc_wr;
      // hit when offset is below the region size
      if (found && diff_ab[ADDR_W]) begin
        res_status <= ST_OK;
        res_idx    <= best_ext[RIDX_W-1:0];
        res_off    <= off_q[SIZE_W-1:0];
      end else begin
        res_status <= ST_MISS;
        res_idx    <= '0;
        res_off    <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_RESULT) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RESULT) && out_free) begin
      out_status <= res_status;
      out_idx    <= res_idx;
      out_off    <= res_off;
      out_wr     <= res_wr;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.region_index = out_idx;
  assign rsp.offset       = out_off;
  assign rsp.is_write     = out_wr;

  // checks
  `ARD_ASSERT_NEXT(a_busy_after_beat, req.valid && req.ready, !req.ready, "ready after request beat")
  `ARD_ASSERT_SAME(a_scan_in_range, state == S_SCAN, scan_ptr <= count, "scan pointer past count")
  `ARD_ASSERT_SAME(a_best_not_above, found, best_base <= acc_addr, "best base above address")

endmodule

// ===== dv/address_region_decoder_top_tb.sv =====
// self-checking testbench for the address region decoder: directed and random region traffic
`timescale 1ns / 1ps

module address_region_decoder_top_tb;
  import ard_pkg::*;

  // the one mode value that the block ignores
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 620;
  localparam int unsigned DRAIN_CYCLES = MAX_REGIONS_DEF + 24;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RIDX_W-1:0]   region_index;
    logic [SIZE_W-1:0]   offset;
    logic                is_write;
  } decode_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ard_req_if req_ch ();
  ard_rsp_if rsp_ch ();

  address_region_decoder_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow of the region table
  logic [ADDR_W-1:0] tbl_base [MAX_REGIONS_DEF];
  logic [SIZE_W-1:0] tbl_size [MAX_REGIONS_DEF];
  int unsigned       tbl_count = 0;

  decode_result_t pending_decodes [$];
  int             fail_count = 0;
  logic           steady_flow = 1'b0;
  logic           hold_rsp = 1'b0;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // expected answer for one request beat, updating the shadow table
  function automatic decode_result_t decode_item(input logic [MODE_W-1:0] m,
                                                 input logic [ADDR_W-1:0] a,
                                                 input logic [SIZE_W-1:0] s);
    decode_result_t    r;
    logic [ADDR_W-1:0] lookup;
    logic [ADDR_W-1:0] diff;
    logic              found;
    int unsigned       best;
    r = '0;
    found = 1'b0;
    best = 0;
    case (m)
      MODE_CLEAR: begin
        tbl_count = 0;
      end
      MODE_REG: begin
        if (tbl_count >= MAX_REGIONS_DEF) begin
          r.status = ST_FULL;
        end else begin
          tbl_base[tbl_count] = a;
          tbl_size[tbl_count] = s;
          r.status = ST_OK;
          r.region_index = tbl_count[RIDX_W-1:0];
          tbl_count++;
        end
      end
      MODE_ACCESS: begin
        r.is_write = a[WRITE_BIT_DEF];
        lookup = a;
        lookup[WRITE_BIT_DEF] = 1'b0;
        // greatest base not above the address, later entry wins on a tie
        for (int unsigned i = 0; i < tbl_count; i++) begin
          if (tbl_base[i] <= lookup && (!found || tbl_base[i] >= tbl_base[best])) begin
            best = i;
            found = 1'b1;
          end
        end
        diff = lookup - (found ? tbl_base[best] : '0);
        if (found && diff < {1'b0, tbl_size[best]}) begin
          r.status = ST_OK;
          r.region_index = best[RIDX_W-1:0];
          r.offset = diff[SIZE_W-1:0];
        end else begin
          r.status = ST_MISS;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // response check first, then prediction for the request beat of this edge
  always @(posedge clk) begin
    decode_result_t want;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_decodes.size() == 0) begin
          $error("response beat with no request outstanding");
          fail_count++;
        end else begin
          want = pending_decodes.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            fail_count++;
          end
          if (rsp_ch.region_index !== want.region_index) begin
            $error("region_index: expected %0d, got %0d", want.region_index,
                   rsp_ch.region_index);
            fail_count++;
          end
          if (rsp_ch.offset !== want.offset) begin
            $error("offset: expected %h, got %h", want.offset, rsp_ch.offset);
            fail_count++;
          end
          if (rsp_ch.is_write !== want.is_write) begin
            $error("is_write: expected %0d, got %0d", want.is_write, rsp_ch.is_write);
            fail_count++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        pending_decodes.push_back(decode_item(req_ch.mode, req_ch.address,
                                              req_ch.region_size));
      end
    end
  end

  // response side back-pressure
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= steady_flow || ($urandom_range(99) >= 26);
      end
    end
  end

  // offer one request beat, with random idle cycles ahead of it
  task automatic send_item(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] a,
                           input logic [SIZE_W-1:0] s);
    while (!steady_flow && $urandom_range(99) < 26) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= m;
    req_ch.address <= a;
    req_ch.region_size <= s;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
  endtask

  // clears and lookups on an empty table
  task automatic test_empty_and_clear();
    send_item(MODE_ACCESS, 32'h0000_0000, '0);
    send_item(MODE_ACCESS, 32'hFFFF_FFFF, '1);
    send_item(MODE_CLEAR, 32'hFFFF_FFFF, '1);
    send_item(MODE_ACCESS, 32'h8000_0000, '0);
  endtask

  // tie on equal bases, size bounds, write bit, bases out of order
  task automatic test_lookup_rules();
    send_item(MODE_REG, 32'h0000_0100, 31'h100);
    send_item(MODE_REG, 32'h0000_0100, 31'h10);
    send_item(MODE_ACCESS, 32'h0000_0150, '0);
    send_item(MODE_ACCESS, 32'h8000_0105, '0);
    send_item(MODE_ACCESS, 32'h0000_0050, '0);
    send_item(MODE_REG, 32'h7FFF_FFF0, 31'h7FFF_FFFF);
    send_item(MODE_ACCESS, 32'hFFFF_FFFF, '0);
    send_item(MODE_REG, 32'hFFFF_FFFF, 31'h0);
    send_item(MODE_REG, 32'h0000_0080, 31'h0);
    send_item(MODE_ACCESS, 32'h0000_0080, '0);
    send_item(MODE_REG, 32'h0000_0000, 31'h7FFF_FFFF);
    send_item(MODE_ACCESS, 32'h0000_007F, '0);
    send_item(MODE_ACCESS, 32'h7FFF_FFEF, '1);
  endtask

  // ignored mode value leaves the table alone
  task automatic test_unused_mode();
    send_item(MODE_UNUSED, 32'hFFFF_FFFF, '1);
    send_item(MODE_UNUSED, $urandom, SIZE_W'($urandom));
    send_item(MODE_ACCESS, 32'h0000_0105, '0);
  endtask

  // six regions are left from the lookup checks: fill the rest, then overflow
  task automatic test_table_full();
    for (int k = 1; k <= 10; k++) begin
      send_item(MODE_REG, 32'h1000_0000 + k * 32'h1000, 31'h800);
    end
    send_item(MODE_REG, 32'h2000_0000, 31'h10);
    send_item(MODE_REG, 32'hFFFF_FFFF, '1);
    send_item(MODE_ACCESS, 32'h9000_3004, '0);
    send_item(MODE_CLEAR, '0, '0);
  endtask

  // receiver holds off while requests keep coming
  task automatic test_output_stall();
    fork
      begin
        hold_rsp <= 1'b1;
        repeat (300) @(posedge clk);
        hold_rsp <= 1'b0;
      end
    join_none
    for (int k = 0; k < 8; k++) begin
      send_item(MODE_REG, 32'h0100_0000 * k, 31'h0080_0000);
    end
    for (int k = 0; k < 32; k++) begin
      send_item(MODE_ACCESS, {1'($urandom_range(1)), 3'b000, 28'($urandom)}, '0);
    end
  endtask

  // region maps built in ascending order, probed near their bounds, plus noise
  task automatic test_random_traffic();
    int unsigned       sent;
    int unsigned       n_regions;
    int unsigned       n_probes;
    int unsigned       pick;
    logic [ADDR_W-1:0] cursor;
    logic [ADDR_W-1:0] step;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] span;
    logic [ADDR_W-1:0] map_bases [$];
    logic [SIZE_W-1:0] map_spans [$];
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // stretch with no idling on either side
      steady_flow <= (sent >= 300 && sent < 400);
      if ($urandom_range(9) < 8 || map_bases.size() > MAX_REGIONS_DEF) begin
        send_item(MODE_CLEAR, $urandom, SIZE_W'($urandom));
        map_bases.delete();
        map_spans.delete();
        sent++;
      end
      n_regions = ($urandom_range(3) == 0) ? $urandom_range(1, MAX_REGIONS_DEF + 2)
                                           : $urandom_range(1, 5);
      cursor = $urandom_range(0, 32'h7000_0000);
      for (int k = 0; k < n_regions; k++) begin
        step = ($urandom_range(2) == 0) ? $urandom_range(1, 64)
                                        : $urandom_range(1, 32'h0080_0000);
        case ($urandom_range(9))
          0: span = SIZE_W'($urandom);
          1: span = '1;
          default: span = SIZE_W'($urandom_range(0, step + step / 4));
        endcase
        if ($urandom_range(9) == 0) begin
          // out-of-order base anywhere in the address space
          send_item(MODE_REG, $urandom, span);
          map_bases.push_back(ADDR_W'(0));
          map_spans.push_back(span);
        end else begin
          send_item(MODE_REG, cursor, span);
          map_bases.push_back(cursor);
          map_spans.push_back(span);
          cursor += step;
        end
        sent++;
      end
      n_probes = $urandom_range(4, 20);
      for (int k = 0; k < n_probes; k++) begin
        pick = $urandom_range(0, map_bases.size() - 1);
        case ($urandom_range(19))
          0: begin
            send_item(MODE_UNUSED, $urandom, SIZE_W'($urandom));
            continue;
          end
          1, 2: addr = $urandom;
          3: addr = map_bases[pick] - $urandom_range(1, 4);
          default: addr = map_bases[pick] + $urandom_range(0, {1'b0, map_spans[pick]} + 4);
        endcase
        addr[WRITE_BIT_DEF] = 1'($urandom_range(1));
        send_item(MODE_ACCESS, addr, SIZE_W'($urandom));
        sent++;
      end
    end
    steady_flow <= 1'b0;
  endtask

  // test sequence
  initial begin
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_CLEAR;
    req_ch.address = '0;
    req_ch.region_size = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_clear();
    test_lookup_rules();
    test_unused_mode();
    test_table_full();
    test_output_stall();
    test_random_traffic();
    req_ch.valid <= 1'b0;
    while (pending_decodes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
